/* hw/rtl/vmalu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmalu_pkg
// Shared operation codes, control bundle and default sizes of the word ALU.
// ----------------------------------------------------------------------------
package vmalu_pkg;

  localparam int DefaultWordWidth   = 16;
  localparam int DefaultNarrowWidth = 8;
  localparam int OpWidth            = 5;

  typedef enum logic [OpWidth-1:0] {
    OpAnd  = 5'd0,
    OpOr   = 5'd1,
    OpXnor = 5'd2,
    OpXor  = 5'd3,
    OpShl  = 5'd4,
    OpShr  = 5'd5,
    OpAdd  = 5'd6,
    OpSub  = 5'd7,
    OpMul  = 5'd8,
    OpDiv  = 5'd9,
    OpMod  = 5'd10,
    OpMin  = 5'd11,
    OpMax  = 5'd12,
    OpGte  = 5'd13,
    OpLte  = 5'd14,
    OpEq   = 5'd15,
    OpNeq  = 5'd16,
    OpGt   = 5'd17,
    OpLt   = 5'd18,
    OpInv  = 5'd19,
    OpInc  = 5'd20,
    OpDec  = 5'd21,
    OpPass = 5'd22
  } op_e;

  // Control that travels with each beat down the divider chain.
  typedef struct packed {
    logic valid;
    logic sel_div;
    logic sel_mod;
    logic narrow;
    logic test;
    logic compare;
    logic div_zero;
  } cell_ctrl_t;

endpackage

/* hw/rtl/vmalu_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmalu_front
// Entry stage: evaluate all operations but divide and modulo, and seed the divider.
// ----------------------------------------------------------------------------
module vmalu_front import vmalu_pkg::*; #(
  parameter int WORD_WIDTH = DefaultWordWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [OpWidth-1:0]    op_i,
  input  logic [WORD_WIDTH-1:0] operand_a_i,
  input  logic [WORD_WIDTH-1:0] operand_b_i,
  input  logic                  narrow_dest_i,
  output cell_ctrl_t            ctrl_o,
  output logic [WORD_WIDTH-1:0] val_o,
  output logic [WORD_WIDTH-1:0] rem_o,
  output logic [WORD_WIDTH-1:0] dq_o,
  output logic [WORD_WIDTH-1:0] div_o
);

  cell_ctrl_t            ctrl_d, ctrl_q;
  logic [WORD_WIDTH-1:0] val_d, val_q;
  logic [WORD_WIDTH-1:0] dq_q, div_q;
  logic [WORD_WIDTH-1:0] mul_lo;
  logic                  b_zero;

  assign mul_lo = operand_a_i * operand_b_i;
  assign b_zero = (operand_b_i == '0);

  always_comb begin
    ctrl_d        = '0;
    ctrl_d.valid  = start_i;
    ctrl_d.narrow = narrow_dest_i;
    val_d         = '0;
    unique case (op_e'(op_i))
      OpAnd:  val_d = operand_a_i & operand_b_i;
      OpOr:   val_d = operand_a_i | operand_b_i;
      OpXnor: val_d = ~(operand_a_i ^ operand_b_i);
      OpXor:  val_d = operand_a_i ^ operand_b_i;
      OpShl:  val_d = (operand_b_i >= WORD_WIDTH) ? '0 : (operand_a_i << operand_b_i);
      OpShr:  val_d = (operand_b_i >= WORD_WIDTH) ? '0 : (operand_a_i >> operand_b_i);
      OpAdd:  val_d = operand_a_i + operand_b_i;
      OpSub:  val_d = operand_a_i - operand_b_i;
      OpMul:  val_d = mul_lo;
      OpDiv: begin
        ctrl_d.sel_div  = 1'b1;
        ctrl_d.div_zero = b_zero;
      end
      OpMod: begin
        ctrl_d.sel_mod  = 1'b1;
        ctrl_d.div_zero = b_zero;
      end
      OpMin:  val_d = (operand_a_i < operand_b_i) ? operand_a_i : operand_b_i;
      OpMax:  val_d = (operand_a_i > operand_b_i) ? operand_a_i : operand_b_i;
      OpGte: begin
        ctrl_d.compare = 1'b1;
        ctrl_d.test    = (operand_a_i >= operand_b_i);
      end
      OpLte: begin
        ctrl_d.compare = 1'b1;
        ctrl_d.test    = (operand_a_i <= operand_b_i);
      end
      OpEq: begin
        ctrl_d.compare = 1'b1;
        ctrl_d.test    = (operand_a_i == operand_b_i);
      end
      OpNeq: begin
        ctrl_d.compare = 1'b1;
        ctrl_d.test    = (operand_a_i != operand_b_i);
      end
      OpGt: begin
        ctrl_d.compare = 1'b1;
        ctrl_d.test    = (operand_a_i > operand_b_i);
      end
      OpLt: begin
        ctrl_d.compare = 1'b1;
        ctrl_d.test    = (operand_a_i < operand_b_i);
      end
      OpInv:  val_d = ~operand_a_i;
      OpInc:  val_d = operand_a_i + WORD_WIDTH'(1);
      OpDec:  val_d = operand_a_i - WORD_WIDTH'(1);
      OpPass: val_d = operand_a_i;
      default: val_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    dq_q  <= operand_a_i;
    div_q <= operand_b_i;
  end

  assign ctrl_o = ctrl_q;
  assign val_o  = val_q;
  assign rem_o  = '0;
  assign dq_o   = dq_q;
  assign div_o  = div_q;

endmodule

/* hw/rtl/vmalu_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmalu_div_cell
// One restoring divide step: retire one quotient bit and pass the beat on.
// ----------------------------------------------------------------------------
module vmalu_div_cell import vmalu_pkg::*; #(
  parameter int WORD_WIDTH = DefaultWordWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctrl_t            ctrl_i,
  input  logic [WORD_WIDTH-1:0] val_i,
  input  logic [WORD_WIDTH-1:0] rem_i,
  input  logic [WORD_WIDTH-1:0] dq_i,
  input  logic [WORD_WIDTH-1:0] div_i,
  output cell_ctrl_t            ctrl_o,
  output logic [WORD_WIDTH-1:0] val_o,
  output logic [WORD_WIDTH-1:0] rem_o,
  output logic [WORD_WIDTH-1:0] dq_o,
  output logic [WORD_WIDTH-1:0] div_o
);

  cell_ctrl_t            ctrl_q;
  logic [WORD_WIDTH-1:0] val_q, rem_q, dq_q, div_q;
  logic [WORD_WIDTH:0]   trial;
  logic [WORD_WIDTH:0]   diff;
  logic                  fits;
  logic [WORD_WIDTH-1:0] rem_d, dq_d;

  // Shift the next dividend bit into the partial remainder, subtract if it fits.
  // A zero divisor always fits, so the quotient fills with ones and the
  // remainder ends as the dividend.
  assign trial = {rem_i, dq_i[WORD_WIDTH-1]};
  assign diff  = trial - {1'b0, div_i};
  assign fits  = (trial >= {1'b0, div_i});
  assign rem_d = fits ? diff[WORD_WIDTH-1:0] : trial[WORD_WIDTH-1:0];
  assign dq_d  = {dq_i[WORD_WIDTH-2:0], fits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_i;
    rem_q <= rem_d;
    dq_q  <= dq_d;
    div_q <= div_i;
  end

  assign ctrl_o = ctrl_q;
  assign val_o  = val_q;
  assign rem_o  = rem_q;
  assign dq_o   = dq_q;
  assign div_o  = div_q;

endmodule

/* hw/rtl/vmalu_out.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmalu_out
// Result stage: pick the final value, apply the narrow mask, drive the beat.
// ----------------------------------------------------------------------------
module vmalu_out import vmalu_pkg::*; #(
  parameter int WORD_WIDTH   = DefaultWordWidth,
  parameter int NARROW_WIDTH = DefaultNarrowWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctrl_t            ctrl_i,
  input  logic [WORD_WIDTH-1:0] val_i,
  input  logic [WORD_WIDTH-1:0] rem_i,
  input  logic [WORD_WIDTH-1:0] quo_i,
  output logic                  done_o,
  output logic [WORD_WIDTH-1:0] value_o,
  output logic                  test_flag_o,
  output logic                  is_compare_o,
  output logic                  divide_by_zero_o
);

  localparam int NarrowKeep = (NARROW_WIDTH < WORD_WIDTH) ? NARROW_WIDTH : WORD_WIDTH;
  localparam logic [WORD_WIDTH-1:0] NarrowMask =
    {WORD_WIDTH{1'b1}} >> (WORD_WIDTH - NarrowKeep);

  logic                  done_q;
  logic [WORD_WIDTH-1:0] sel_val, value_d, value_q;
  logic                  test_q, cmp_q, dz_q;

  always_comb begin
    priority if (ctrl_i.sel_div) begin
      sel_val = quo_i;
    end else if (ctrl_i.sel_mod) begin
      sel_val = rem_i;
    end else begin
      sel_val = val_i;
    end
    value_d = ctrl_i.narrow ? (sel_val & NarrowMask) : sel_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    test_q  <= ctrl_i.test;
    cmp_q   <= ctrl_i.compare;
    dz_q    <= ctrl_i.div_zero;
  end

  assign done_o           = done_q;
  assign value_o          = value_q;
  assign test_flag_o      = test_q;
  assign is_compare_o     = cmp_q;
  assign divide_by_zero_o = dz_q;

endmodule

/* hw/rtl/vm_word_alu_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vm_word_alu_core
// Unsigned word ALU of a small virtual machine with a pipelined divider.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                Payload
// -------   ---------  -----------------------  ------------------------------
// command   in         start_i high, busy_o low op_i, operand_a_i, operand_b_i,
//                                               narrow_dest_i
// result    out        done_o, one cycle        value_o, test_flag_o,
//                                               is_compare_o, divide_by_zero_o
//
// One command beat is taken every cycle; busy_o stays low.
// Every beat passes, in order, one entry stage, WORD_WIDTH divider cells
// (one quotient bit each) and one result register before it leaves on done_o.
// All operations travel the same chain, so results never reorder.
// Reset clears the valid bits of every stage; operand data is not reset.
// The receiver cannot stall: each result stands on the ports for one cycle.
// ----------------------------------------------------------------------------
module vm_word_alu_core import vmalu_pkg::*; #(
  parameter int WORD_WIDTH   = DefaultWordWidth,
  parameter int NARROW_WIDTH = DefaultNarrowWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [OpWidth-1:0]    op_i,
  input  logic [WORD_WIDTH-1:0] operand_a_i,
  input  logic [WORD_WIDTH-1:0] operand_b_i,
  input  logic                  narrow_dest_i,
  output logic                  done_o,
  output logic [WORD_WIDTH-1:0] value_o,
  output logic                  test_flag_o,
  output logic                  is_compare_o,
  output logic                  divide_by_zero_o
);

  localparam int Latency = WORD_WIDTH + 2;

  // Stage k of the chain feeds cell k; stage WORD_WIDTH feeds the result stage.
  cell_ctrl_t            chain_ctrl [WORD_WIDTH+1];
  logic [WORD_WIDTH-1:0] chain_val  [WORD_WIDTH+1];
  logic [WORD_WIDTH-1:0] chain_rem  [WORD_WIDTH+1];
  logic [WORD_WIDTH-1:0] chain_dq   [WORD_WIDTH+1];
  logic [WORD_WIDTH-1:0] chain_div  [WORD_WIDTH+1];

  // The chain advances every cycle, so a new command is always welcome.
  assign busy_o = 1'b0;

  // Evaluate all operations but divide and modulo, and load the dividend and divisor.
  vmalu_front #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .op_i          (op_i),
    .operand_a_i   (operand_a_i),
    .operand_b_i   (operand_b_i),
    .narrow_dest_i (narrow_dest_i),
    .ctrl_o        (chain_ctrl[0]),
    .val_o         (chain_val[0]),
    .rem_o         (chain_rem[0]),
    .dq_o          (chain_dq[0]),
    .div_o         (chain_div[0])
  );

  // Advance each beat one cell per cycle, retiring one quotient bit per cell,
  // most significant bit first.
  for (genvar k = 0; k < WORD_WIDTH; k++) begin : g_cell
    vmalu_div_cell #(
      .WORD_WIDTH (WORD_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (chain_ctrl[k]),
      .val_i  (chain_val[k]),
      .rem_i  (chain_rem[k]),
      .dq_i   (chain_dq[k]),
      .div_i  (chain_div[k]),
      .ctrl_o (chain_ctrl[k+1]),
      .val_o  (chain_val[k+1]),
      .rem_o  (chain_rem[k+1]),
      .dq_o   (chain_dq[k+1]),
      .div_o  (chain_div[k+1])
    );
  end

  // Select quotient, remainder or the early value, then mask for narrow targets.
  // The divisor copy at the end of the chain is not needed any more.
  vmalu_out #(
    .WORD_WIDTH   (WORD_WIDTH),
    .NARROW_WIDTH (NARROW_WIDTH)
  ) u_out (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (chain_ctrl[WORD_WIDTH]),
    .val_i            (chain_val[WORD_WIDTH]),
    .rem_i            (chain_rem[WORD_WIDTH]),
    .quo_i            (chain_dq[WORD_WIDTH]),
    .done_o           (done_o),
    .value_o          (value_o),
    .test_flag_o      (test_flag_o),
    .is_compare_o     (is_compare_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

`ifndef SYNTHESIS
  // Every command beat comes out after the fixed chain latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##(Latency) done_o)
    else $error("result beat missing after chain latency");

  // A result beat must trace back to a command beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Latency))
    else $error("result beat without a command beat");

  // Comparisons give a zero value and never a divide fault.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && is_compare_o |-> value_o == '0 && !divide_by_zero_o)
    else $error("comparison beat with value or divide fault");

  // The test flag only rises on comparisons.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && test_flag_o |-> is_compare_o)
    else $error("test flag outside a comparison");
`endif

endmodule

/* dv/tb_vm_word_alu_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vm_word_alu_core
// Self-checking bench for the word ALU: a queued command driver with random
// idle bursts feeds the core, and a monitor checks every done beat against a
// local model of the ALU, in order, field by field.
// ----------------------------------------------------------------------------
module tb_vm_word_alu_core;
  import vmalu_pkg::*;

  localparam int WordW   = DefaultWordWidth;
  localparam int NarrowW = DefaultNarrowWidth;
  // Entry stage, one divider cell per quotient bit, result register.
  localparam int Latency = WordW + 2;
  // Codes past the last defined operation decode to nothing.
  localparam logic [OpWidth-1:0] OpFirstUnused = 5'd23;
  localparam logic [OpWidth-1:0] OpLastCode    = 5'd31;
  localparam int RandomBeats = 1400;
  // No idle bursts once this few commands remain.
  localparam int QuietTail   = 300;

  typedef struct packed {
    logic [OpWidth-1:0] code;
    logic [WordW-1:0]   a;
    logic [WordW-1:0]   b;
    logic               narrow;
  } alu_cmd_t;

  typedef struct packed {
    logic [WordW-1:0] value;
    logic             test;
    logic             compare;
    logic             div_zero;
  } alu_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               start_i       = 1'b0;
  logic [OpWidth-1:0] op_i          = '0;
  logic [WordW-1:0]   operand_a_i   = '0;
  logic [WordW-1:0]   operand_b_i   = '0;
  logic               narrow_dest_i = 1'b0;
  logic               busy_o;
  logic               done_o;
  logic [WordW-1:0]   value_o;
  logic               test_flag_o;
  logic               is_compare_o;
  logic               divide_by_zero_o;

  alu_cmd_t    pending_cmds[$];
  alu_result_t awaited_results[$];
  int          total_cmds     = 0;
  int          accepted_beats = 0;
  int          mismatch_count = 0;
  int          compare_beats  = 0;
  int          div_zero_beats = 0;
  int          narrow_beats   = 0;
  int          unused_beats   = 0;
  int          idle_left      = 0;
  bit          beat_taken     = 1'b0;

  vm_word_alu_core #(
    .WORD_WIDTH  (WordW),
    .NARROW_WIDTH(NarrowW)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .op_i            (op_i),
    .operand_a_i     (operand_a_i),
    .operand_b_i     (operand_b_i),
    .narrow_dest_i   (narrow_dest_i),
    .done_o          (done_o),
    .value_o         (value_o),
    .test_flag_o     (test_flag_o),
    .is_compare_o    (is_compare_o),
    .divide_by_zero_o(divide_by_zero_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Compute what the ALU must return for one command. Work in 32 bits so
  // that products and borrows are visible, then wrap to the word.
  function automatic alu_result_t alu_outcome(alu_cmd_t c);
    alu_result_t r;
    logic [31:0] wide;
    logic [31:0] a32;
    logic [31:0] b32;
    r    = '0;
    wide = '0;
    a32  = 32'(c.a);
    b32  = 32'(c.b);
    case (c.code)
      OpAnd:  wide = a32 & b32;
      OpOr:   wide = a32 | b32;
      OpXnor: wide = ~(a32 ^ b32);
      OpXor:  wide = a32 ^ b32;
      // Shift amounts of a full word or more flush the value.
      OpShl:  wide = (b32 >= WordW) ? '0 : (a32 << b32);
      OpShr:  wide = (b32 >= WordW) ? '0 : (a32 >> b32);
      OpAdd:  wide = a32 + b32;
      OpSub:  wide = a32 - b32;
      OpMul:  wide = a32 * b32;
      OpDiv: begin
        if (b32 == 0) begin
          wide       = '1;
          r.div_zero = 1'b1;
        end else begin
          wide = a32 / b32;
        end
      end
      OpMod: begin
        // Remainder by zero hands back the dividend.
        if (b32 == 0) begin
          wide       = a32;
          r.div_zero = 1'b1;
        end else begin
          wide = a32 % b32;
        end
      end
      OpMin:  wide = (a32 < b32) ? a32 : b32;
      OpMax:  wide = (a32 > b32) ? a32 : b32;
      OpGte: begin r.compare = 1'b1; r.test = (a32 >= b32); end
      OpLte: begin r.compare = 1'b1; r.test = (a32 <= b32); end
      OpEq:  begin r.compare = 1'b1; r.test = (a32 == b32); end
      OpNeq: begin r.compare = 1'b1; r.test = (a32 != b32); end
      OpGt:  begin r.compare = 1'b1; r.test = (a32 > b32);  end
      OpLt:  begin r.compare = 1'b1; r.test = (a32 < b32);  end
      OpInv:  wide = ~a32;
      OpInc:  wide = a32 + 1;
      OpDec:  wide = a32 - 1;
      OpPass: wide = a32;
      default: wide = '0;
    endcase
    r.value = wide[WordW-1:0];
    if (c.narrow) begin
      r.value = r.value & WordW'((1 << NarrowW) - 1);
    end
    return r;
  endfunction

  // Bias operands toward the corners: zero, all ones, sign bit, byte edges
  // and small counts that land around the shift limit.
  function automatic logic [WordW-1:0] operand_word();
    logic [WordW-1:0] w;
    case ($urandom_range(0, 7))
      0:       w = '0;
      1:       w = '1;
      2:       w = WordW'($urandom_range(0, WordW + 4));
      3: begin
        case ($urandom_range(0, 3))
          0:       w = 16'h8000;
          1:       w = 16'h7FFF;
          2:       w = 16'h00FF;
          default: w = 16'h0100;
        endcase
      end
      default: w = WordW'($urandom);
    endcase
    return w;
  endfunction

  function automatic alu_cmd_t random_cmd();
    alu_cmd_t c;
    if ($urandom_range(0, 19) == 0) begin
      c.code = OpWidth'($urandom_range(OpFirstUnused, OpLastCode));
    end else begin
      c.code = OpWidth'($urandom_range(OpAnd, OpPass));
    end
    c.a      = operand_word();
    c.b      = operand_word();
    c.narrow = 1'($urandom_range(0, 1));
    case (c.code)
      OpShl, OpShr: if ($urandom_range(0, 1) == 0) c.b = WordW'($urandom_range(0, WordW + 2));
      OpDiv, OpMod: if ($urandom_range(0, 6) == 0) c.b = '0;
      OpGte, OpLte, OpEq, OpNeq, OpGt, OpLt: if ($urandom_range(0, 3) == 0) c.b = c.a;
      default: ;
    endcase
    return c;
  endfunction

  // Driver: change inputs on the falling edge. Hold a command until the
  // core takes it, then advance to the next one or drop start for a burst.
  always @(negedge clk_i) begin
    alu_cmd_t c;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && !beat_taken) begin
      // Hold the current beat; the core has not taken it yet.
    end else if (idle_left > 0) begin
      idle_left <= idle_left - 1;
      start_i   <= 1'b0;
    end else if (pending_cmds.size() == 0) begin
      start_i <= 1'b0;
    end else if (pending_cmds.size() > QuietTail && $urandom_range(0, 9) == 0) begin
      // This cycle is the first of the burst.
      idle_left <= $urandom_range(0, 17);
      start_i   <= 1'b0;
    end else begin
      c             = pending_cmds.pop_front();
      op_i          <= c.code;
      operand_a_i   <= c.a;
      operand_b_i   <= c.b;
      narrow_dest_i <= c.narrow;
      start_i       <= 1'b1;
    end
  end

  // Monitor: sample on the rising edge. Check any done beat against the
  // oldest expectation, then log the command beat taken at this edge.
  always @(posedge clk_i) begin
    alu_cmd_t    c;
    alu_result_t want;
    if (!rst_ni) begin
      beat_taken = 1'b0;
    end else begin
      if (done_o) begin
        if (awaited_results.size() == 0) begin
          $error("result beat with nothing outstanding: value %h", value_o);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          if (value_o !== want.value) begin
            $error("value: expected %h, got %h", want.value, value_o);
            mismatch_count++;
          end
          if (test_flag_o !== want.test) begin
            $error("test_flag: expected %b, got %b", want.test, test_flag_o);
            mismatch_count++;
          end
          if (is_compare_o !== want.compare) begin
            $error("is_compare: expected %b, got %b", want.compare, is_compare_o);
            mismatch_count++;
          end
          if (divide_by_zero_o !== want.div_zero) begin
            $error("divide_by_zero: expected %b, got %b", want.div_zero,
                   divide_by_zero_o);
            mismatch_count++;
          end
        end
      end
      beat_taken = start_i && !busy_o;
      if (beat_taken) begin
        c.code   = op_i;
        c.a      = operand_a_i;
        c.b      = operand_b_i;
        c.narrow = narrow_dest_i;
        want     = alu_outcome(c);
        awaited_results.push_back(want);
        accepted_beats++;
        if (want.compare) compare_beats++;
        if (want.div_zero) div_zero_beats++;
        if (c.narrow) narrow_beats++;
        if (c.code >= OpFirstUnused) unused_beats++;
      end
    end
  end

  // Watchdog: fail the run if it hangs.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    alu_cmd_t c;
    int       drain;

    // Directed: every operation once with full-scale operands. Odd codes get
    // a zero divisor, even codes an all-ones one, so divide hits zero, modulo
    // divides by itself, shift left goes past the word and shift right moves
    // by zero. Narrow follows bit 1 of the code, so it alternates in pairs.
    for (int k = OpAnd; k <= OpPass; k++) begin
      c.code   = OpWidth'(k);
      c.a      = '1;
      c.b      = k[0] ? '0 : '1;
      c.narrow = k[1];
      pending_cmds.push_back(c);
    end
    c = '{code: OpMod, a: 16'h1234, b: '0, narrow: 1'b0};
    pending_cmds.push_back(c);
    c = '{code: OpShl, a: 16'h0001, b: 16'd15, narrow: 1'b0};
    pending_cmds.push_back(c);
    c = '{code: OpShl, a: 16'h0001, b: 16'd16, narrow: 1'b0};
    pending_cmds.push_back(c);
    c = '{code: OpShr, a: 16'h8000, b: 16'd15, narrow: 1'b1};
    pending_cmds.push_back(c);
    c = '{code: OpLastCode, a: '1, b: '1, narrow: 1'b1};
    pending_cmds.push_back(c);

    for (int n = 0; n < RandomBeats; n++) begin
      pending_cmds.push_back(random_cmd());
    end
    total_cmds = pending_cmds.size();

    // Release reset on a falling edge, away from the sampling edge.
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (accepted_beats < total_cmds) @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    // Catch any stray done beat left behind.
    for (drain = 0; drain < Latency + 4; drain++) @(posedge clk_i);

    $display("Ran %0d command beats over all %0d op codes, %0d of them unused codes.",
             accepted_beats, 1 << OpWidth, unused_beats);
    $display("Saw %0d compares, %0d zero divisors and %0d narrow destinations.",
             compare_beats, div_zero_beats, narrow_beats);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* vm_word_alu_core.f */
hw/rtl/vmalu_pkg.sv
hw/rtl/vmalu_front.sv
hw/rtl/vmalu_div_cell.sv
hw/rtl/vmalu_out.sv
hw/rtl/vm_word_alu_core.sv
dv/tb_vm_word_alu_core.sv
